>>> rtl/core/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: bilinear image scaler shared definitions
// Sizes, widths, item types and codes used by the scaler modules.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Frame store and fixed-point geometry
  localparam int MAX_SRC_WIDTH  = 256;
  localparam int MAX_SRC_HEIGHT = 256;
  localparam int FRAC_BITS      = 16;

  localparam int XW  = $clog2(MAX_SRC_WIDTH);   // source column bits
  localparam int YW  = $clog2(MAX_SRC_HEIGHT);  // source row bits
  localparam int HXW = XW - 1;                  // column bits inside one bank
  localparam int HYW = YW - 1;                  // row bits inside one bank
  localparam int SWW = XW + 1;                  // clamped width value
  localparam int SHW = YW + 1;                  // clamped height value

  // Fixed field widths
  localparam int SIZE_W  = 9;
  localparam int STEP_W  = 24;
  localparam int COORD_W = 10;
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int POS_W   = STEP_W + COORD_W;    // step * coordinate
  localparam int INT_W   = POS_W - FRAC_BITS;   // integer part of position
  localparam int WGT_W   = FRAC_BITS + 1;       // weight 0 .. 1.0
  localparam int ACC1_W  = CH_W + WGT_W;        // horizontal blend
  localparam int ACC2_W  = ACC1_W + WGT_W;      // vertical blend

  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_INTERP = 1'b1
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_COL_STEP   = 2'd2,
    REG_ROW_STEP   = 2'd3
  } reg_index_t;

  // Input item
  typedef struct packed {
    opcode_t              opcode;
    logic [COORD_W-1:0]   col;
    logic [COORD_W-1:0]   row;
    logic [CH_W-1:0]      red_in;
    logic [CH_W-1:0]      green_in;
    logic [CH_W-1:0]      blue_in;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [CH_W-1:0]      red_out;
    logic [CH_W-1:0]      green_out;
    logic [CH_W-1:0]      blue_out;
  } rsp_t;

  // Decoded configuration seen by the front end
  typedef struct packed {
    logic [SWW-1:0]       width;
    logic [SHW-1:0]       height;
    logic [XW-1:0]        x_max;      // width - 2
    logic [YW-1:0]        y_max;      // height - 2
    logic [STEP_W-1:0]    col_step;
    logic [STEP_W-1:0]    row_step;
  } cfg_t;

  // Work item handed from front end to back end. Banks are split by column
  // and row parity; *_e / *_o are the in-bank addresses for the even / odd
  // bank. Loads carry the same address in both.
  typedef struct packed {
    opcode_t              op;
    logic                 par_x;
    logic                 par_y;
    logic [HXW-1:0]       xe;
    logic [HXW-1:0]       xo;
    logic [HYW-1:0]       ye;
    logic [HYW-1:0]       yo;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_W-1:0]     rgb;
  } task_t;

endpackage

>>> rtl/core/bis_front.sv
// ----------------------------------------------------------------------------
// bis_front: command front end
// Scales destination coordinates to source positions, saturates them, drops
// loads that fall outside the source and pushes work items to the queue.
// ----------------------------------------------------------------------------
module bis_front (
  input  logic          clk,
  input  logic          rst,
  input  bis_pkg::cfg_t cfg,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  bis_pkg::cmd_t cmd,
  output logic          push,
  output bis_pkg::task_t push_task,
  input  logic          q_full
);

  // stage 1: captured item and scaled positions
  logic                            f1_valid;
  bis_pkg::opcode_t                f1_op;
  logic [bis_pkg::COORD_W-1:0]     f1_col;
  logic [bis_pkg::COORD_W-1:0]     f1_row;
  logic [bis_pkg::PIX_W-1:0]       f1_rgb;
  logic [bis_pkg::POS_W-1:0]       f1_px;
  logic [bis_pkg::POS_W-1:0]       f1_py;

  // stage 2: work item waiting for queue space
  logic                            f2_valid;
  bis_pkg::task_t                  f2_task;

  logic                            f1_ready;
  logic                            f2_ready;
  logic                            f1_keep;
  bis_pkg::task_t                  f1_task;

  logic [bis_pkg::INT_W-1:0]       ix;
  logic [bis_pkg::INT_W-1:0]       iy;
  logic [bis_pkg::XW-1:0]          x;
  logic [bis_pkg::YW-1:0]          y;
  logic [bis_pkg::XW:0]            x_inc;
  logic [bis_pkg::YW:0]            y_inc;

  // elastic handshake through both stages
  assign f2_ready  = !f2_valid || !q_full;
  assign f1_ready  = !f1_valid || f2_ready;
  assign cmd_stall = !f1_ready;
  assign push      = f2_valid && !q_full;
  assign push_task = f2_task;

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (f1_ready) begin
      f1_valid <= cmd_valid;
    end
    if (f1_ready && cmd_valid) begin
      f1_op  <= cmd.opcode;
      f1_col <= cmd.col;
      f1_row <= cmd.row;
      f1_rgb <= {cmd.red_in, cmd.green_in, cmd.blue_in};
      f1_px  <= cfg.col_step * bis_pkg::POS_W'(cmd.col);
      f1_py  <= cfg.row_step * bis_pkg::POS_W'(cmd.row);
    end
  end

  // saturate integer parts and build the bank addresses
  always_comb begin
    ix = f1_px[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];
    iy = f1_py[bis_pkg::POS_W-1:bis_pkg::FRAC_BITS];
    x  = (ix > bis_pkg::INT_W'(cfg.x_max)) ? cfg.x_max : ix[bis_pkg::XW-1:0];
    y  = (iy > bis_pkg::INT_W'(cfg.y_max)) ? cfg.y_max : iy[bis_pkg::YW-1:0];
    x_inc = {1'b0, x} + 1'b1;
    y_inc = {1'b0, y} + 1'b1;

    f1_task.op  = f1_op;
    f1_task.rgb = f1_rgb;
    f1_task.fx  = f1_px[bis_pkg::FRAC_BITS-1:0];
    f1_task.fy  = f1_py[bis_pkg::FRAC_BITS-1:0];
    if (f1_op == bis_pkg::OP_INTERP) begin
      f1_task.par_x = x[0];
      f1_task.par_y = y[0];
      f1_task.xe    = x_inc[bis_pkg::HXW:1];
      f1_task.xo    = x[bis_pkg::XW-1:1];
      f1_task.ye    = y_inc[bis_pkg::HYW:1];
      f1_task.yo    = y[bis_pkg::YW-1:1];
    end else begin
      f1_task.par_x = f1_col[0];
      f1_task.par_y = f1_row[0];
      f1_task.xe    = f1_col[bis_pkg::XW-1:1];
      f1_task.xo    = f1_col[bis_pkg::XW-1:1];
      f1_task.ye    = f1_row[bis_pkg::YW-1:1];
      f1_task.yo    = f1_row[bis_pkg::YW-1:1];
    end

    // a load outside the source image does nothing and is dropped here
    f1_keep = (f1_op == bis_pkg::OP_INTERP) ||
              ((int'(f1_col) < int'(cfg.width)) && (int'(f1_row) < int'(cfg.height)));
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      f2_valid <= 1'b0;
    end else if (f2_ready) begin
      f2_valid <= f1_valid && f1_keep;
    end
    if (f2_ready) begin
      f2_task <= f1_task;
    end
  end

endmodule

>>> rtl/core/bis_queue.sv
// ----------------------------------------------------------------------------
// bis_queue: work item queue
// Small FIFO between front end and back end so each side stalls on its own.
// ----------------------------------------------------------------------------
module bis_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bis_pkg::task_t push_task,
  input  logic           pop,
  output bis_pkg::task_t head,
  output logic           full,
  output logic           empty
);

  localparam int QPW = $clog2(bis_pkg::QUEUE_DEPTH);
  localparam int QCW = $clog2(bis_pkg::QUEUE_DEPTH + 1);

  bis_pkg::task_t   slots [bis_pkg::QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [QCW-1:0]   count;

  assign full  = (count == QCW'(bis_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_task;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(bis_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(bis_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/bis_back.sv
// ----------------------------------------------------------------------------
// bis_back: frame store and blend pipeline
// Four parity banks of the frame store; loads write one bank, interpolations
// read all four at once and blend horizontally, then vertically.
// ----------------------------------------------------------------------------
module bis_back (
  input  logic           clk,
  input  logic           rst,
  input  bis_pkg::task_t head,
  input  logic           empty,
  output logic           pop,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bis_pkg::rsp_t  rsp
);

  localparam int BAW        = bis_pkg::HXW + bis_pkg::HYW;
  localparam int BANK_DEPTH = 1 << BAW;
  localparam logic [bis_pkg::WGT_W-1:0] ONE = bis_pkg::WGT_W'(1) << bis_pkg::FRAC_BITS;

  logic                                adv;
  logic [3:0][bis_pkg::PIX_W-1:0]      rd_data;

  // stage 1: bank read data in flight
  logic                            s1_valid;
  bis_pkg::opcode_t                s1_op;
  logic                            s1_px;
  logic                            s1_py;
  logic [bis_pkg::FRAC_BITS-1:0]   s1_fx;
  logic [bis_pkg::FRAC_BITS-1:0]   s1_fy;

  // stage 2: horizontal blends
  logic                            s2_valid;
  logic                            s2_interp;
  logic [bis_pkg::ACC1_W-1:0]      s2_top [3];
  logic [bis_pkg::ACC1_W-1:0]      s2_bot [3];
  logic [bis_pkg::WGT_W-1:0]       s2_gy;
  logic [bis_pkg::WGT_W-1:0]       s2_fy;

  logic [bis_pkg::PIX_W-1:0]       nb_a, nb_b, nb_c, nb_d;
  logic [bis_pkg::WGT_W-1:0]       fx_w, gx_w, fy_w, gy_w;
  logic [bis_pkg::ACC1_W-1:0]      top_next [3];
  logic [bis_pkg::ACC1_W-1:0]      bot_next [3];
  logic [bis_pkg::ACC2_W-1:0]      sum [3];

  // whole back end moves unless a finished result is held
  assign adv = !rsp_valid || !rsp_stall;
  assign pop = adv && !empty;

  // frame store banks, indexed by {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic BX = ((b % 2) == 1);
    localparam logic BY = ((b / 2) == 1);

    logic [bis_pkg::PIX_W-1:0] mem [BANK_DEPTH];
    logic [BAW-1:0]            addr;
    logic [bis_pkg::PIX_W-1:0] rd_q;

    assign addr       = {BY ? head.yo : head.ye, BX ? head.xo : head.xe};
    assign rd_data[b] = rd_q;

    always_ff @(posedge clk) begin
      if (pop && head.op == bis_pkg::OP_LOAD && head.par_x == BX && head.par_y == BY) begin
        mem[addr] <= head.rgb;
      end
      if (pop && head.op == bis_pkg::OP_INTERP) begin
        rd_q <= mem[addr];
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= !empty;
    end
    if (adv) begin
      s1_op <= head.op;
      s1_px <= head.par_x;
      s1_py <= head.par_y;
      s1_fx <= head.fx;
      s1_fy <= head.fy;
    end
  end

  // put the four neighbours back in place and blend each row
  always_comb begin
    nb_a = s1_py ? (s1_px ? rd_data[3] : rd_data[2]) : (s1_px ? rd_data[1] : rd_data[0]);
    nb_b = s1_py ? (s1_px ? rd_data[2] : rd_data[3]) : (s1_px ? rd_data[0] : rd_data[1]);
    nb_c = s1_py ? (s1_px ? rd_data[1] : rd_data[0]) : (s1_px ? rd_data[3] : rd_data[2]);
    nb_d = s1_py ? (s1_px ? rd_data[0] : rd_data[1]) : (s1_px ? rd_data[2] : rd_data[3]);
    fx_w = bis_pkg::WGT_W'(s1_fx);
    gx_w = ONE - fx_w;
    fy_w = bis_pkg::WGT_W'(s1_fy);
    gy_w = ONE - fy_w;
    for (int ch = 0; ch < 3; ch++) begin
      top_next[ch] = bis_pkg::ACC1_W'(nb_a[bis_pkg::PIX_W-1-bis_pkg::CH_W*ch -: bis_pkg::CH_W])
                     * gx_w
                   + bis_pkg::ACC1_W'(nb_b[bis_pkg::PIX_W-1-bis_pkg::CH_W*ch -: bis_pkg::CH_W])
                     * fx_w;
      bot_next[ch] = bis_pkg::ACC1_W'(nb_c[bis_pkg::PIX_W-1-bis_pkg::CH_W*ch -: bis_pkg::CH_W])
                     * gx_w
                   + bis_pkg::ACC1_W'(nb_d[bis_pkg::PIX_W-1-bis_pkg::CH_W*ch -: bis_pkg::CH_W])
                     * fx_w;
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s2_interp <= (s1_op == bis_pkg::OP_INTERP);
      s2_top    <= top_next;
      s2_bot    <= bot_next;
      s2_gy     <= gy_w;
      s2_fy     <= fy_w;
    end
  end

  // vertical blend; keep the integer part of the 2*FRAC_BITS product
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum[ch] = bis_pkg::ACC2_W'(s2_top[ch]) * s2_gy
              + bis_pkg::ACC2_W'(s2_bot[ch]) * s2_fy;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s2_valid && s2_interp;
    end
    if (adv) begin
      rsp.red_out   <= sum[0][2*bis_pkg::FRAC_BITS +: bis_pkg::CH_W];
      rsp.green_out <= sum[1][2*bis_pkg::FRAC_BITS +: bis_pkg::CH_W];
      rsp.blue_out  <= sum[2][2*bis_pkg::FRAC_BITS +: bis_pkg::CH_W];
    end
  end

endmodule

>>> rtl/core/bilinear_image_scaler.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler: bilinear resize engine with on-chip frame store
// Loads source pixels and returns bilinear-interpolated destination pixels.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid / cmd_stall / cmd): a load item writes one RGB
//   source pixel at (col,row); loads outside the configured source size are
//   dropped. An interpolate item names a destination (col,row) and yields
//   exactly one rsp item with the blended RGB value. Loads yield nothing.
//   rsp channel (rsp_valid / rsp_stall / rsp): results come out in the order
//   of their interpolate items.
//   cfg port: cfg_wr_en, cfg_index, cfg_data write src_width, src_height,
//   col_step and row_step (Q8.16); write only while the block is idle.
// Timing:
//   One item per cycle sustained while results are not stalled. A result
//   passes two front stages (step multiply, saturate), the queue, the
//   bank read and two blend stages. The store is split into four banks by
//   column and row parity, so all four neighbours come from a single read.
// Reset: registers return to 256 x 256 and unit steps, pipeline and queue
//   empty; the frame store is not cleared and must be loaded before use.
// Stall: a stalled result holds and stops the back end; the 4-entry queue
//   then fills and cmd_stall rises once the front end is full as well.
// ----------------------------------------------------------------------------
module bilinear_image_scaler (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_stall,
  input  bis_pkg::cmd_t                   cmd,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output bis_pkg::rsp_t                   rsp,
  input  logic                            cfg_wr_en,
  input  logic [bis_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bis_pkg::STEP_W-1:0]      cfg_data
);

  logic [bis_pkg::SIZE_W-1:0] src_width;
  logic [bis_pkg::SIZE_W-1:0] src_height;
  logic [bis_pkg::STEP_W-1:0] col_step;
  logic [bis_pkg::STEP_W-1:0] row_step;

  bis_pkg::cfg_t  cfg;
  logic           push;
  bis_pkg::task_t push_task;
  bis_pkg::task_t head;
  logic           q_full;
  logic           q_empty;
  logic           pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= bis_pkg::SIZE_W'(256);
      src_height <= bis_pkg::SIZE_W'(256);
      col_step   <= bis_pkg::STEP_W'(65536);
      row_step   <= bis_pkg::STEP_W'(65536);
    end else if (cfg_wr_en) begin
      unique case (bis_pkg::reg_index_t'(cfg_index))
        bis_pkg::REG_SRC_WIDTH:  src_width  <= cfg_data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_SRC_HEIGHT: src_height <= cfg_data[bis_pkg::SIZE_W-1:0];
        bis_pkg::REG_COL_STEP:   col_step   <= cfg_data;
        bis_pkg::REG_ROW_STEP:   row_step   <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes into [2, max] and derive saturation limits
  always_comb begin
    if (src_width < bis_pkg::SIZE_W'(2)) begin
      cfg.width = bis_pkg::SWW'(2);
    end else if (int'(src_width) > bis_pkg::MAX_SRC_WIDTH) begin
      cfg.width = bis_pkg::SWW'(bis_pkg::MAX_SRC_WIDTH);
    end else begin
      cfg.width = bis_pkg::SWW'(src_width);
    end
    if (src_height < bis_pkg::SIZE_W'(2)) begin
      cfg.height = bis_pkg::SHW'(2);
    end else if (int'(src_height) > bis_pkg::MAX_SRC_HEIGHT) begin
      cfg.height = bis_pkg::SHW'(bis_pkg::MAX_SRC_HEIGHT);
    end else begin
      cfg.height = bis_pkg::SHW'(src_height);
    end
    cfg.x_max    = bis_pkg::XW'(cfg.width - bis_pkg::SWW'(2));
    cfg.y_max    = bis_pkg::YW'(cfg.height - bis_pkg::SHW'(2));
    cfg.col_step = col_step;
    cfg.row_step = row_step;
  end

  bis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .push      (push),
    .push_task (push_task),
    .q_full    (q_full)
  );

  bis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_task (push_task),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  bis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> rtl/core/bis_checker.sv
// ----------------------------------------------------------------------------
// bis_checker: port-level checks for the scaler
// Watches the top-level channels for result holding and reset behavior.
// ----------------------------------------------------------------------------
module bis_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input bis_pkg::rsp_t rsp
);

  // a stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_rsp: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // reset leaves the front end ready for an item
  a_rst_cmd: assert property (@(posedge clk)
    rst |=> !cmd_stall)
    else $error("input stalled right after reset");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_stall (cmd_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> test/tb_bilinear_image_scaler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bilinear_image_scaler: self-checking bench for the bilinear scaler
// Loads source pixels and requests interpolated destination pixels over a
// series of size and step settings. A local predictor keeps its own copy of
// the frame store and computes every blended pixel. Each result is compared
// in order against it, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bilinear_image_scaler;
  import bis_pkg::*;

  localparam int ITEM_TARGET = 950;
  localparam int DRAIN_CYC   = 12;    // pipeline latency plus margin
  localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake at all
  localparam int HOLD_AT     = 300;   // item count that starts the long hold
  localparam int HOLD_CYC    = 80;
  localparam int CALM_LO     = 500;   // no random gaps in this item window
  localparam int CALM_HI     = 700;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  rsp_t        rsp;
  logic        cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
  logic [STEP_W-1:0]    cfg_data = '0;

  bilinear_image_scaler dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Predictor state: register copy, frame store copy, pending pixels
  logic [SIZE_W-1:0] src_w  = 9'd256;
  logic [SIZE_W-1:0] src_h  = 9'd256;
  logic [STEP_W-1:0] step_x = 24'h010000;
  logic [STEP_W-1:0] step_y = 24'h010000;
  logic [PIX_W-1:0]  frame_copy [0:MAX_SRC_WIDTH*MAX_SRC_HEIGHT-1];
  bit                written    [0:MAX_SRC_WIDTH*MAX_SRC_HEIGHT-1];
  rsp_t              blend_q [$];
  cmd_t              cmd_q [$];

  bit          cmd_taken = 1'b0;
  int unsigned n_cmd = 0, n_load = 0, n_drop = 0, n_interp = 0, n_pix = 0;
  int unsigned n_err = 0, n_queued = 0, n_settings = 1, quiet_cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          calm;

  assign calm = (n_cmd >= CALM_LO) && (n_cmd < CALM_HI);

  function automatic int unsigned eff_size(logic [SIZE_W-1:0] v, int unsigned lim);
    if (v < 2) return 2;
    if (v > lim) return lim;
    return v;
  endfunction

  // Top-left source neighbour and fractions for a destination pixel
  function automatic void corner(input logic [COORD_W-1:0] c, r,
                                 output logic [XW-1:0] x, output logic [YW-1:0] y,
                                 output logic [FRAC_BITS-1:0] fx, fy);
    logic [POS_W-1:0] px, py;
    logic [INT_W-1:0] ix, iy;
    int unsigned      w, h;
    w  = eff_size(src_w, MAX_SRC_WIDTH);
    h  = eff_size(src_h, MAX_SRC_HEIGHT);
    px = POS_W'(step_x) * POS_W'(c);
    py = POS_W'(step_y) * POS_W'(r);
    ix = px[POS_W-1:FRAC_BITS];
    iy = py[POS_W-1:FRAC_BITS];
    fx = px[FRAC_BITS-1:0];
    fy = py[FRAC_BITS-1:0];
    // past the edge: integer part saturates, fraction kept
    if (ix > w - 2) ix = INT_W'(w - 2);
    if (iy > h - 2) iy = INT_W'(h - 2);
    x = ix[XW-1:0];
    y = iy[YW-1:0];
  endfunction

  // Exact weighted sum of one channel, truncated
  function automatic logic [CH_W-1:0] mix(logic [CH_W-1:0] a, b, c, d,
                                          logic [FRAC_BITS-1:0] fx, fy);
    longint unsigned gx, gy, s;
    gx = (64'd1 << FRAC_BITS) - fx;
    gy = (64'd1 << FRAC_BITS) - fy;
    s  = a * gx * gy + b * fx * gy + c * gx * fy + d * fx * fy;
    return CH_W'(s >> (2 * FRAC_BITS));
  endfunction

  // Update the store copy or queue the blended pixel for one accepted item
  task automatic apply_item(cmd_t it);
    logic [XW-1:0]        x, xn;
    logic [YW-1:0]        y, yn;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [PIX_W-1:0]     a, b, c, d;
    rsp_t                 p;
    if (it.opcode == OP_LOAD) begin
      if (it.col < eff_size(src_w, MAX_SRC_WIDTH) &&
          it.row < eff_size(src_h, MAX_SRC_HEIGHT)) begin
        frame_copy[{it.row[YW-1:0], it.col[XW-1:0]}] =
          {it.red_in, it.green_in, it.blue_in};
        n_load++;
      end else begin
        n_drop++;
      end
    end else begin
      corner(it.col, it.row, x, y, fx, fy);
      xn = x + 1'b1;
      yn = y + 1'b1;
      a = frame_copy[{y, x}];
      b = frame_copy[{y, xn}];
      c = frame_copy[{yn, x}];
      d = frame_copy[{yn, xn}];
      p.red_out   = mix(a[23:16], b[23:16], c[23:16], d[23:16], fx, fy);
      p.green_out = mix(a[15:8], b[15:8], c[15:8], d[15:8], fx, fy);
      p.blue_out  = mix(a[7:0], b[7:0], c[7:0], d[7:0], fx, fy);
      blend_q.push_back(p);
      n_interp++;
    end
  endtask

  // Sample both channels: predict on accepted items, check accepted results
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      cmd_taken <= cmd_valid && !cmd_stall;
      if (cmd_valid && !cmd_stall) begin
        apply_item(cmd);
        n_cmd++;
      end
      if (rsp_valid && !rsp_stall) begin
        n_pix++;
        if (blend_q.size() == 0) begin
          $error("result with no interpolate item pending");
          n_err++;
        end else begin
          want = blend_q.pop_front();
          if (rsp.red_out !== want.red_out) begin
            $error("red_out: expected %0d, got %0d", want.red_out, rsp.red_out);
            n_err++;
          end
          if (rsp.green_out !== want.green_out) begin
            $error("green_out: expected %0d, got %0d", want.green_out, rsp.green_out);
            n_err++;
          end
          if (rsp.blue_out !== want.blue_out) begin
            $error("blue_out: expected %0d, got %0d", want.blue_out, rsp.blue_out);
            n_err++;
          end
        end
      end
    end
    // watchdog on cycles with no handshake
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall) || cfg_wr_en || rst)
      quiet_cyc = 0;
    else
      quiet_cyc++;
    if (quiet_cyc >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Item driver: holds a stalled item, otherwise offers the next one
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd_valid && !cmd_taken) begin
      cmd_valid <= 1'b1;
    end else if (cmd_q.size() != 0 && (calm || $urandom_range(0, 99) >= 21)) begin
      cmd       <= cmd_q.pop_front();
      cmd_valid <= 1'b1;
    end else begin
      cmd_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls plus one long hold while items keep coming
  always @(negedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (!hold_done && n_cmd >= HOLD_AT && cmd_q.size() > 20) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYC - 1;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 21);
    end
  end

  // Wait until every item is taken and every pixel returned, then drain
  task automatic wait_idle();
    while (cmd_q.size() != 0 || cmd_valid || blend_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic set_phase(logic [SIZE_W-1:0] w, h, logic [STEP_W-1:0] sx, sy);
    reg_index_t idx;
    wait_idle();
    for (int i = 0; i < 4; i++) begin
      idx = reg_index_t'(i);
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= idx;
      case (idx)
        REG_SRC_WIDTH:  cfg_data <= STEP_W'(w);
        REG_SRC_HEIGHT: cfg_data <= STEP_W'(h);
        REG_COL_STEP:   cfg_data <= sx;
        default:        cfg_data <= sy;
      endcase
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    src_w  = w;
    src_h  = h;
    step_x = sx;
    step_y = sy;
    n_settings++;
  endtask

  task automatic push_cmd(opcode_t op, logic [COORD_W-1:0] c, r, logic [PIX_W-1:0] rgb);
    cmd_t it;
    it.opcode   = op;
    it.col      = c;
    it.row      = r;
    it.red_in   = rgb[23:16];
    it.green_in = rgb[15:8];
    it.blue_in  = rgb[7:0];
    cmd_q.push_back(it);
    n_queued++;
  endtask

  task automatic queue_load(logic [COORD_W-1:0] c, r, logic [PIX_W-1:0] rgb);
    push_cmd(OP_LOAD, c, r, rgb);
    if (c < eff_size(src_w, MAX_SRC_WIDTH) && r < eff_size(src_h, MAX_SRC_HEIGHT))
      written[{r[YW-1:0], c[XW-1:0]}] = 1'b1;
  endtask

  // Interpolate, first loading any neighbour never written
  task automatic queue_interp(logic [COORD_W-1:0] c, r);
    logic [XW-1:0]        x, xs;
    logic [YW-1:0]        y, ys;
    logic [FRAC_BITS-1:0] fx, fy;
    corner(c, r, x, y, fx, fy);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        xs = x + XW'(dx);
        ys = y + YW'(dy);
        if (!written[{ys, xs}])
          queue_load(COORD_W'(xs), COORD_W'(ys), PIX_W'($urandom));
      end
    end
    push_cmd(OP_INTERP, c, r, PIX_W'($urandom));
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return SIZE_W'($urandom_range(2, 24));
    if (k < 80) return 9'd256;
    if (k < 90) return SIZE_W'($urandom_range(0, 511));
    return SIZE_W'($urandom_range(25, 255));
  endfunction

  // Mostly the (src-1)/dst step software would compute, sometimes extremes
  function automatic logic [STEP_W-1:0] pick_step(int unsigned sz, int unsigned dst);
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 60) return STEP_W'(((sz - 1) << FRAC_BITS) / dst);
    if (k < 75) return STEP_W'($urandom_range(0, 24'hFF0000));
    if (k < 85) return '0;
    if (k < 95) return 24'hFF0000;
    return 24'h010000;
  endfunction

  // Stimulus
  initial begin
    int unsigned dst_x, dst_y, phase_end, k, w, h;
    logic [SIZE_W-1:0] w9, h9;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset setting, corners, loads outside the source
    queue_load(0, 0, 24'hFF00FF);
    queue_load(255, 255, 24'h00FF00);
    queue_load(256, 0, 24'hFFFFFF);
    queue_load(0, 256, 24'hFFFFFF);
    queue_load(1023, 1023, 24'hFFFFFF);
    queue_interp(0, 0);
    queue_interp(1, 0);
    queue_interp(255, 255);
    queue_interp(1023, 1023);
    queue_interp(0, 1023);

    // half and one-and-a-half steps, black/white midpoint
    set_phase(9'd256, 9'd256, 24'h008000, 24'h018000);
    queue_load(0, 0, 24'h000000);
    queue_load(1, 0, 24'hFFFFFF);
    queue_interp(1, 0);
    queue_interp(1, 1);
    queue_interp(3, 5);
    queue_interp(1023, 1);

    // zero steps with sizes clamped up to two
    set_phase(9'd0, 9'd1, 24'h000000, 24'h000000);
    queue_interp(0, 0);
    queue_interp(1023, 1023);
    queue_interp(7, 300);

    // largest steps with sizes clamped down, past the edge except at (0,0)
    set_phase(9'd511, 9'd511, 24'hFF0000, 24'hFF0000);
    queue_interp(1, 1);
    queue_interp(0, 0);
    queue_interp(1023, 1023);

    // random settings with random loads and interpolates
    while (n_queued < ITEM_TARGET) begin
      w9    = pick_size();
      h9    = pick_size();
      w     = eff_size(w9, MAX_SRC_WIDTH);
      h     = eff_size(h9, MAX_SRC_HEIGHT);
      dst_x = $urandom_range(1, 48);
      dst_y = $urandom_range(1, 48);
      set_phase(w9, h9, pick_step(w, dst_x), pick_step(h, dst_y));
      phase_end = n_queued + $urandom_range(40, 120);
      while (n_queued < phase_end) begin
        k = $urandom_range(0, 99);
        if (k < 55) begin
          if ($urandom_range(0, 4) == 0)
            queue_interp(COORD_W'($urandom_range(0, 1023)),
                         COORD_W'($urandom_range(0, 1023)));
          else
            queue_interp(COORD_W'($urandom_range(0, dst_x + 1)),
                         COORD_W'($urandom_range(0, dst_y + 1)));
        end else if (k < 85) begin
          queue_load(COORD_W'($urandom_range(0, w - 1)),
                     COORD_W'($urandom_range(0, h - 1)), PIX_W'($urandom));
        end else begin
          queue_load(COORD_W'($urandom_range(0, 1023)),
                     COORD_W'($urandom_range(0, 1023)), PIX_W'($urandom));
        end
      end
    end

    wait_idle();
    $display("Run covered %0d settings, %0d stored loads, %0d dropped loads,",
             n_settings, n_load, n_drop);
    $display("and %0d interpolates with %0d pixels checked", n_interp, n_pix);
    if (n_err == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> bilinear_image_scaler.f
rtl/core/bis_pkg.sv
rtl/core/bis_front.sv
rtl/core/bis_queue.sv
rtl/core/bis_back.sv
rtl/core/bilinear_image_scaler.sv
rtl/core/bis_checker.sv
test/tb_bilinear_image_scaler.sv
